// ===== hw/rtl/voxel_label_mode_filter_six_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the voxel label mode filter
// Wrappers that give every concurrent check the same clock, reset and report.
// ----------------------------------------------------------------------------
`ifndef VOXEL_LABEL_MODE_FILTER_SIX_UNIT_ASSERT_SVH
`define VOXEL_LABEL_MODE_FILTER_SIX_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VLMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vlmf check failed");

// Next-cycle implication, checked outside reset.
`define VLMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vlmf check failed");

`endif

// ===== hw/rtl/vlmf_pkg.sv =====
// ----------------------------------------------------------------------------
// vlmf_pkg
// Shared types, constants and helper functions of the voxel label mode filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vlmf_pkg;

  // Default label width.
  localparam int unsigned LABEL_BITS_DEF = 31;

  // Six face neighbours, compared in three pairs.
  localparam int unsigned NB_NUM   = 6;
  localparam int unsigned PAIR_NUM = NB_NUM / 2;
  localparam int unsigned CNT_BITS = 3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } cfg_reg_e;

  typedef logic [NB_NUM-1:0]   nb_mask_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  // Flags after the range and centre compares.
  typedef struct packed {
    logic     ctr_in;
    nb_mask_t same;
    nb_mask_t cand;
  } cmp_flags_t;

  // Flags after counting.
  typedef struct packed {
    logic                elig;
    cnt_t                same_cnt;
    nb_mask_t            cand;
    cnt_t [NB_NUM-1:0]   cnt;
  } cnt_flags_t;

  // One contender of the selection tree.
  typedef struct packed {
    logic v;
    cnt_t cnt;
  } pick_t;

  // Flags after the first selection level.
  typedef struct packed {
    logic                  elig;
    cnt_t                  same_cnt;
    pick_t [PAIR_NUM-1:0]  pick;
  } sel_flags_t;

  // Number of set bits in a neighbour mask.
  function automatic cnt_t popcount6(nb_mask_t m);
    cnt_t sum;
    sum = '0;
    for (int i = 0; i < NB_NUM; i++) begin
      sum = sum + cnt_t'(m[i]);
    end
    return sum;
  endfunction

  // True when contender a wins over b: higher count, ties to the smaller label.
  function automatic logic beats(pick_t a, pick_t b, logic a_lab_lt);
    return a.v && (!b.v || (a.cnt > b.cnt) || ((a.cnt == b.cnt) && a_lab_lt));
  endfunction

endpackage

// ===== hw/rtl/voxel_label_mode_filter_six_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_label_mode_filter_six_unit
// Six-neighbour mode filter on voxel labels: replaces an in-range centre label
// by the most frequent in-range neighbour label when that label outvotes the
// neighbours equal to the centre.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_stall_o    centre and six neighbour labels
//   out      source     out_valid_o / out_stall_i  new_label_o, changed_o
//   cfg      sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Four register stages (compare, count, pair select, decide). An accepted
// transaction passes through the compare, count, pair select and decide
// registers in that order before it is valid on the output.
// One transaction is taken per cycle while the output is not stalled.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and a stall backs up only as far as the pipeline is full.
// Reset clears the valid bits and sets both range registers to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "voxel_label_mode_filter_six_unit_assert.svh"

module voxel_label_mode_filter_six_unit #(
  parameter int unsigned LABEL_BITS = vlmf_pkg::LABEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port.
  input  logic                                cfg_we_i,
  input  logic [vlmf_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [LABEL_BITS-1:0]               cfg_wdata_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [LABEL_BITS-1:0]               center_label_i,
  input  logic [LABEL_BITS-1:0]               x_minus_label_i,
  input  logic [LABEL_BITS-1:0]               x_plus_label_i,
  input  logic [LABEL_BITS-1:0]               y_minus_label_i,
  input  logic [LABEL_BITS-1:0]               y_plus_label_i,
  input  logic [LABEL_BITS-1:0]               z_minus_label_i,
  input  logic [LABEL_BITS-1:0]               z_plus_label_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [LABEL_BITS-1:0]               new_label_o,
  output logic                                changed_o
);

  logic [LABEL_BITS-1:0]                          range_low_q, range_high_q;
  logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]    nb_in;
  logic                                           en1, en2, en3, en4;
  logic                                           s1_valid, s2_valid, s3_valid;
  logic [LABEL_BITS-1:0]                          s1_centre, s2_centre, s3_centre;
  logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]    s1_nb, s2_nb;
  logic [vlmf_pkg::PAIR_NUM-1:0][LABEL_BITS-1:0]  s3_lab;
  vlmf_pkg::cmp_flags_t                           s1_flags;
  vlmf_pkg::cnt_flags_t                           s2_flags;
  vlmf_pkg::sel_flags_t                           s3_flags;

  // Range registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= '0;
    end else if (cfg_we_i) begin
      case (vlmf_pkg::cfg_reg_e'(cfg_idx_i))
        vlmf_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_wdata_i;
        vlmf_pkg::REG_RANGE_HIGH: range_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Neighbour order follows the field order of the input transaction.
  assign nb_in[0] = x_minus_label_i;
  assign nb_in[1] = x_plus_label_i;
  assign nb_in[2] = y_minus_label_i;
  assign nb_in[3] = y_plus_label_i;
  assign nb_in[4] = z_minus_label_i;
  assign nb_in[5] = z_plus_label_i;

  // Stage enables: a stage loads when it is empty or its content moves on.
  assign en4        = !out_valid_o || !out_stall_i;
  assign en3        = !s3_valid || en4;
  assign en2        = !s2_valid || en3;
  assign en1        = !s1_valid || en2;
  assign in_stall_o = !en1;

  vlmf_compare #(.LABEL_BITS(LABEL_BITS)) u_compare (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en1),
    .valid_i      (in_valid_i),
    .range_low_i  (range_low_q),
    .range_high_i (range_high_q),
    .centre_i     (center_label_i),
    .nb_i         (nb_in),
    .valid_o      (s1_valid),
    .centre_o     (s1_centre),
    .nb_o         (s1_nb),
    .flags_o      (s1_flags)
  );

  vlmf_count #(.LABEL_BITS(LABEL_BITS)) u_count (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en2),
    .valid_i  (s1_valid),
    .centre_i (s1_centre),
    .nb_i     (s1_nb),
    .flags_i  (s1_flags),
    .valid_o  (s2_valid),
    .centre_o (s2_centre),
    .nb_o     (s2_nb),
    .flags_o  (s2_flags)
  );

  vlmf_select #(.LABEL_BITS(LABEL_BITS)) u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en3),
    .valid_i  (s2_valid),
    .centre_i (s2_centre),
    .nb_i     (s2_nb),
    .flags_i  (s2_flags),
    .valid_o  (s3_valid),
    .centre_o (s3_centre),
    .lab_o    (s3_lab),
    .flags_o  (s3_flags)
  );

  vlmf_decide #(.LABEL_BITS(LABEL_BITS)) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en4),
    .valid_i     (s3_valid),
    .centre_i    (s3_centre),
    .lab_i       (s3_lab),
    .flags_i     (s3_flags),
    .valid_o     (out_valid_o),
    .new_label_o (new_label_o),
    .changed_o   (changed_o)
  );

  // The input stalls only when every stage is full and the output is held.
  `VLMF_ASSERT_SAME(a_stall_full, clk_i, rst_ni, in_stall_o, s1_valid && s2_valid && s3_valid && out_valid_o && out_stall_i)
  // An accepted transaction lands in the first stage.
  `VLMF_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, in_valid_i && !in_stall_o, s1_valid)
  // A held first stage keeps its transaction.
  `VLMF_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid && !en2, s1_valid)

endmodule

// ===== hw/rtl/vlmf_compare.sv =====
// ----------------------------------------------------------------------------
// vlmf_compare
// First stage: range checks and compares of each neighbour against the centre.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlmf_compare #(
  parameter int unsigned LABEL_BITS = vlmf_pkg::LABEL_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  logic [LABEL_BITS-1:0]                        range_low_i,
  input  logic [LABEL_BITS-1:0]                        range_high_i,
  input  logic [LABEL_BITS-1:0]                        centre_i,
  input  logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]  nb_i,
  output logic                                         valid_o,
  output logic [LABEL_BITS-1:0]                        centre_o,
  output logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]  nb_o,
  output vlmf_pkg::cmp_flags_t                         flags_o
);

  logic                                         valid_q;
  logic [LABEL_BITS-1:0]                        centre_q;
  logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]  nb_q;
  vlmf_pkg::cmp_flags_t                         flags_d, flags_q;

  // Classify each neighbour as same, candidate or neither.
  always_comb begin
    flags_d.ctr_in = (centre_i >= range_low_i) && (centre_i <= range_high_i);
    for (int i = 0; i < vlmf_pkg::NB_NUM; i++) begin
      flags_d.same[i] = (nb_i[i] == centre_i);
      flags_d.cand[i] = flags_d.ctr_in && !flags_d.same[i] &&
                        (nb_i[i] >= range_low_i) && (nb_i[i] <= range_high_i);
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      centre_q <= centre_i;
      nb_q     <= nb_i;
      flags_q  <= flags_d;
    end
  end

  assign valid_o  = valid_q;
  assign centre_o = centre_q;
  assign nb_o     = nb_q;
  assign flags_o  = flags_q;

endmodule

// ===== hw/rtl/vlmf_count.sv =====
// ----------------------------------------------------------------------------
// vlmf_count
// Second stage: pairwise neighbour compares and per-candidate vote counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlmf_count #(
  parameter int unsigned LABEL_BITS = vlmf_pkg::LABEL_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  logic [LABEL_BITS-1:0]                        centre_i,
  input  logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]  nb_i,
  input  vlmf_pkg::cmp_flags_t                         flags_i,
  output logic                                         valid_o,
  output logic [LABEL_BITS-1:0]                        centre_o,
  output logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]  nb_o,
  output vlmf_pkg::cnt_flags_t                         flags_o
);

  logic                                         valid_q;
  logic [LABEL_BITS-1:0]                        centre_q;
  logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]  nb_q;
  vlmf_pkg::cnt_flags_t                         flags_d, flags_q;
  vlmf_pkg::nb_mask_t [vlmf_pkg::NB_NUM-1:0]    match;

  // Equality matrix between neighbours, each pair compared once.
  always_comb begin
    for (int a = 0; a < vlmf_pkg::NB_NUM; a++) begin
      match[a][a] = 1'b1;
      for (int b = a + 1; b < vlmf_pkg::NB_NUM; b++) begin
        match[a][b] = (nb_i[a] == nb_i[b]);
        match[b][a] = match[a][b];
      end
    end
  end

  // Vote counts and the different-beats-same test.
  always_comb begin
    flags_d.cand     = flags_i.cand;
    flags_d.same_cnt = vlmf_pkg::popcount6(flags_i.same);
    flags_d.elig     = flags_i.ctr_in &&
                       (vlmf_pkg::popcount6(flags_i.cand) > flags_d.same_cnt);
    for (int a = 0; a < vlmf_pkg::NB_NUM; a++) begin
      flags_d.cnt[a] = vlmf_pkg::popcount6(flags_i.cand & match[a]);
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      centre_q <= centre_i;
      nb_q     <= nb_i;
      flags_q  <= flags_d;
    end
  end

  assign valid_o  = valid_q;
  assign centre_o = centre_q;
  assign nb_o     = nb_q;
  assign flags_o  = flags_q;

endmodule

// ===== hw/rtl/vlmf_select.sv =====
// ----------------------------------------------------------------------------
// vlmf_select
// Third stage: first level of the selection tree, one winner per pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlmf_select #(
  parameter int unsigned LABEL_BITS = vlmf_pkg::LABEL_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           en_i,
  input  logic                                           valid_i,
  input  logic [LABEL_BITS-1:0]                          centre_i,
  input  logic [vlmf_pkg::NB_NUM-1:0][LABEL_BITS-1:0]    nb_i,
  input  vlmf_pkg::cnt_flags_t                           flags_i,
  output logic                                           valid_o,
  output logic [LABEL_BITS-1:0]                          centre_o,
  output logic [vlmf_pkg::PAIR_NUM-1:0][LABEL_BITS-1:0]  lab_o,
  output vlmf_pkg::sel_flags_t                           flags_o
);

  logic                                           valid_q;
  logic [LABEL_BITS-1:0]                          centre_q;
  logic [vlmf_pkg::PAIR_NUM-1:0][LABEL_BITS-1:0]  lab_d, lab_q;
  vlmf_pkg::sel_flags_t                           flags_d, flags_q;
  vlmf_pkg::pick_t                                pick_a, pick_b;

  // Pick the better candidate of each neighbour pair.
  always_comb begin
    flags_d.elig     = flags_i.elig;
    flags_d.same_cnt = flags_i.same_cnt;
    pick_a           = '0;
    pick_b           = '0;
    for (int p = 0; p < vlmf_pkg::PAIR_NUM; p++) begin
      pick_a.v   = flags_i.cand[2*p];
      pick_a.cnt = flags_i.cnt[2*p];
      pick_b.v   = flags_i.cand[2*p+1];
      pick_b.cnt = flags_i.cnt[2*p+1];
      if (vlmf_pkg::beats(pick_b, pick_a, nb_i[2*p+1] < nb_i[2*p])) begin
        flags_d.pick[p] = pick_b;
        lab_d[p]        = nb_i[2*p+1];
      end else begin
        flags_d.pick[p] = pick_a;
        lab_d[p]        = nb_i[2*p];
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      centre_q <= centre_i;
      lab_q    <= lab_d;
      flags_q  <= flags_d;
    end
  end

  assign valid_o  = valid_q;
  assign centre_o = centre_q;
  assign lab_o    = lab_q;
  assign flags_o  = flags_q;

endmodule

// ===== hw/rtl/vlmf_decide.sv =====
// ----------------------------------------------------------------------------
// vlmf_decide
// Last stage: final selection, replace-or-keep decision and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlmf_decide #(
  parameter int unsigned LABEL_BITS = vlmf_pkg::LABEL_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           en_i,
  input  logic                                           valid_i,
  input  logic [LABEL_BITS-1:0]                          centre_i,
  input  logic [vlmf_pkg::PAIR_NUM-1:0][LABEL_BITS-1:0]  lab_i,
  input  vlmf_pkg::sel_flags_t                           flags_i,
  output logic                                           valid_o,
  output logic [LABEL_BITS-1:0]                          new_label_o,
  output logic                                           changed_o
);

  logic                   valid_q;
  logic [LABEL_BITS-1:0]  new_label_d, new_label_q;
  logic                   changed_d, changed_q;
  vlmf_pkg::pick_t        win01, win;
  logic [LABEL_BITS-1:0]  lab01, lab_win;

  // Reduce the three pair winners and decide on replacement.
  always_comb begin
    if (vlmf_pkg::beats(flags_i.pick[1], flags_i.pick[0], lab_i[1] < lab_i[0])) begin
      win01 = flags_i.pick[1];
      lab01 = lab_i[1];
    end else begin
      win01 = flags_i.pick[0];
      lab01 = lab_i[0];
    end
    if (vlmf_pkg::beats(flags_i.pick[2], win01, lab_i[2] < lab01)) begin
      win     = flags_i.pick[2];
      lab_win = lab_i[2];
    end else begin
      win     = win01;
      lab_win = lab01;
    end
    changed_d   = flags_i.elig && win.v && (win.cnt > flags_i.same_cnt);
    new_label_d = changed_d ? lab_win : centre_i;
  end

  // Output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      new_label_q <= new_label_d;
      changed_q   <= changed_d;
    end
  end

  assign valid_o     = valid_q;
  assign new_label_o = new_label_q;
  assign changed_o   = changed_q;

endmodule
